// File: hw/rtl/pfsr_pkg.sv
// Shared types and constants for the PI fan speed regulator.
package pfsr_pkg;

    // Result status codes carried on the master tuser.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVER_TEMP = 2'd1,
        ST_SENSOR    = 2'd2,
        ST_HALTED    = 2'd3
    } t_status;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET_TEMP = 3'd0;
    localparam logic [2:0] REG_PANIC_MAIN  = 3'd1;
    localparam logic [2:0] REG_PANIC_BOARD = 3'd2;
    localparam logic [2:0] REG_GAIN_P      = 3'd3;
    localparam logic [2:0] REG_GAIN_I      = 3'd4;
    localparam logic [2:0] REG_USE_BOARD   = 3'd5;
    localparam logic [2:0] REG_RUN_ENABLE  = 3'd6;

    localparam int TEMP_W   = 8;
    localparam int LIMIT_W  = 7;
    localparam int GAIN_W   = 10;
    localparam int SUM_W    = 24;
    localparam int ERR_W    = 9;
    localparam int SPEED_W  = 13;
    localparam int CALC_W   = 37;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] RST_TARGET_TEMP = 7'd42;
    localparam logic [LIMIT_W-1:0] RST_PANIC_MAIN  = 7'd65;
    localparam logic [LIMIT_W-1:0] RST_PANIC_BOARD = 7'd75;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P      = 10'd40;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I      = 10'd40;

    localparam logic signed [CALC_W-1:0] SPEED_BASE = 37'sd4000;
    localparam logic signed [CALC_W-1:0] SPEED_MAX  = 37'sd5700;
    localparam logic signed [CALC_W-1:0] SPEED_MIN  = 37'sd2500;

    localparam logic [SUM_W-1:0] SUM_POS_LIMIT = 24'h7FFFFF;
    localparam logic [SUM_W-1:0] SUM_NEG_LIMIT = 24'h800000;

endpackage

// File: hw/rtl/pi_fan_speed_regulator_core.sv
// PI fan speed regulator with clamping anti-windup: datapath, state and stream ports.
// A transferred tick is captured in the input register; its result is then loaded into
// the output register when that is empty or being read and, while run is enabled, offered
// on the master side. Throughput: one tick per cycle while the master side does not stall;
// the PI step of one tick fits between the input register and the result register, and
// the integral it leaves is ready for the next.
// Reset (synchronous, active low) loads the main-board register defaults, clears the
// integral and the halted flag, and empties both pipeline registers.
module pi_fan_speed_regulator_core
    import pfsr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // Tick stream in.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [15:0]          i_s_tdata,  // [7:0] temp_main, [15:8] temp_board
    input  logic [0:0]           i_s_tuser,  // [0] read_ok
    // Result stream out.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,  // [12:0] fan_speed, [15:13] zero
    output logic [1:0]           o_m_tuser   // [1:0] status
);

    // Configuration registers.
    logic [LIMIT_W-1:0] r_target_temp;
    logic [LIMIT_W-1:0] r_panic_main;
    logic [LIMIT_W-1:0] r_panic_board;
    logic [GAIN_W-1:0]  r_gain_p;
    logic [GAIN_W-1:0]  r_gain_i;
    logic               r_use_board;
    logic               r_run_enable;

    // Input stage.
    logic                     r_in_vld;
    logic signed [TEMP_W-1:0] r_temp_main;
    logic signed [TEMP_W-1:0] r_temp_board;
    logic                     r_read_ok;

    // Loop state.
    logic signed [SUM_W-1:0] r_error_sum;
    logic signed [SUM_W-1:0] n_error_sum;
    logic                    r_halted;
    logic                    n_halted;

    // Output stage.
    logic               r_out_vld;
    logic               n_out_vld;
    logic [SPEED_W-1:0] r_speed;
    logic [SPEED_W-1:0] n_speed;
    t_status            r_status;
    t_status            n_status;

    logic s_accept;
    logic w_adv;

    logic signed [TEMP_W-1:0] w_board_chk;
    logic signed [TEMP_W-1:0] w_temp_sel;
    logic                     w_over_temp;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [SUM_W:0]    w_sum_raw;
    logic signed [SUM_W-1:0]  w_sum_sat;
    logic signed [CALC_W-1:0] w_p_term;
    logic signed [CALC_W-1:0] w_i_term;
    logic signed [CALC_W-1:0] w_speed;

    assign o_cfg_ready = 1'b1;

    assign w_adv      = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_adv;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_speed};
    assign o_m_tuser  = r_status;

    // PI step on the registered tick.
    assign w_board_chk = r_use_board ? r_temp_board : '0;
    assign w_temp_sel  = r_use_board ? r_temp_board : r_temp_main;
    assign w_over_temp = (r_temp_main > $signed({1'b0, r_panic_main}))
                      || (w_board_chk > $signed({1'b0, r_panic_board}));

    assign w_err = $signed({w_temp_sel[TEMP_W-1], w_temp_sel})
                 - $signed({2'b00, r_target_temp});

    assign w_sum_raw = $signed({r_error_sum[SUM_W-1], r_error_sum})
                     + $signed({{(SUM_W+1-ERR_W){w_err[ERR_W-1]}}, w_err});

    // The integral saturates when the 25-bit sum leaves the 24-bit range.
    always_comb begin
        if (w_sum_raw[SUM_W] != w_sum_raw[SUM_W-1]) begin
            w_sum_sat = w_sum_raw[SUM_W] ? $signed(SUM_NEG_LIMIT) : $signed(SUM_POS_LIMIT);
        end else begin
            w_sum_sat = w_sum_raw[SUM_W-1:0];
        end
    end

    assign w_p_term = $signed({{(CALC_W-ERR_W){w_err[ERR_W-1]}}, w_err})
                    * $signed({{(CALC_W-GAIN_W){1'b0}}, r_gain_p});
    assign w_i_term = $signed({{(CALC_W-SUM_W){w_sum_sat[SUM_W-1]}}, w_sum_sat})
                    * $signed({{(CALC_W-GAIN_W){1'b0}}, r_gain_i});
    assign w_speed  = SPEED_BASE + w_p_term + w_i_term;

    always_comb begin
        n_error_sum = r_error_sum;
        n_halted    = r_halted;
        n_speed     = r_speed;
        n_status    = r_status;
        n_out_vld   = r_out_vld && !i_m_tready;
        if (w_adv) begin
            n_out_vld = r_run_enable;
            if (r_run_enable) begin
                n_speed = '0;
                if (r_halted) begin
                    n_status = ST_HALTED;
                end else if (!r_read_ok) begin
                    n_status = ST_SENSOR;
                    n_halted = 1'b1;
                end else if (w_over_temp) begin
                    n_status = ST_OVER_TEMP;
                    n_halted = 1'b1;
                end else begin
                    n_status = ST_OK;
                    if (w_speed > SPEED_MAX) begin
                        n_speed = SPEED_MAX[SPEED_W-1:0];
                    end else if (w_speed < SPEED_MIN) begin
                        n_speed = SPEED_MIN[SPEED_W-1:0];
                    end else begin
                        // Only an unclamped speed commits the new integral.
                        n_speed     = w_speed[SPEED_W-1:0];
                        n_error_sum = w_sum_sat;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_temp <= RST_TARGET_TEMP;
            r_panic_main  <= RST_PANIC_MAIN;
            r_panic_board <= RST_PANIC_BOARD;
            r_gain_p      <= RST_GAIN_P;
            r_gain_i      <= RST_GAIN_I;
            r_use_board   <= 1'b0;
            r_run_enable  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TARGET_TEMP: r_target_temp <= i_cfg_data[LIMIT_W-1:0];
                REG_PANIC_MAIN:  r_panic_main  <= i_cfg_data[LIMIT_W-1:0];
                REG_PANIC_BOARD: r_panic_board <= i_cfg_data[LIMIT_W-1:0];
                REG_GAIN_P:      r_gain_p      <= i_cfg_data;
                REG_GAIN_I:      r_gain_i      <= i_cfg_data;
                REG_USE_BOARD:   r_use_board   <= i_cfg_data[0];
                REG_RUN_ENABLE:  r_run_enable  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_error_sum <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_in_vld    <= s_accept || (r_in_vld && !w_adv);
            r_out_vld   <= n_out_vld;
            r_error_sum <= n_error_sum;
            r_halted    <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_temp_main  <= i_s_tdata[7:0];
            r_temp_board <= i_s_tdata[15:8];
            r_read_ok    <= i_s_tuser[0];
        end
        r_speed  <= n_speed;
        r_status <= n_status;
    end

    // A panic, sensor-fault or halted result never carries a speed.
    a_fault_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_OK)) |-> (o_m_tdata == 16'd0))
        else $error("non-ok result with nonzero fan speed");

    // A regular result always lies inside the clamp window.
    a_ok_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_OK))
            |-> ((o_m_tdata >= 16'd2500) && (o_m_tdata <= 16'd5700)))
        else $error("regular fan speed outside clamp window");

    // Halted is sticky until reset.
    a_halted_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    // The integral only moves when a tick is processed.
    a_sum_idle_stable: assert property (@(posedge i_clk)
        (i_rst_n && !w_adv) |=> (!i_rst_n || $stable(r_error_sum)))
        else $error("integral changed without a processed tick");

endmodule
